/* hdl/blst_pkg.sv */
package blst_pkg;

   localparam int DEPTH    = 64;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int CMP_W    = 12;

   localparam int FUNC_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int IDX_W    = 7;
   localparam int COUNT_W  = 7;
   localparam int STATUS_W = 2;
   localparam int CAP_W    = 7;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

   localparam logic [FUNC_W-1:0] FUNC_APPEND  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_FIND    = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_REVERSE = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_DEDUP   = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd2;

   localparam logic signed [IDX_W-1:0] IDX_NONE = '1;

   typedef struct packed {
      logic [FUNC_W-1:0]         func;
      logic signed [VALUE_W-1:0] value;
   } blst_req_type;

   typedef struct packed {
      logic signed [IDX_W-1:0] index;
      logic [COUNT_W-1:0]      count;
      logic [STATUS_W-1:0]     status;
   } blst_rsp_type;

   typedef struct packed {
      logic               wr_en;
      logic [ADDR_W-1:0]  wr_addr;
      logic [VALUE_W-1:0] wr_data;
      logic [ADDR_W-1:0]  rd_addr_a;
      logic [ADDR_W-1:0]  rd_addr_b;
   } blst_ram_cmd_type;

endpackage

/* hdl/blst_ram.sv */
module blst_ram
   import blst_pkg::*;
(
   input  logic               clock,
   input  blst_ram_cmd_type   cmd,
   output logic [VALUE_W-1:0] rd_data_a,
   output logic [VALUE_W-1:0] rd_data_b
);

   logic [VALUE_W-1:0] entries_ff [DEPTH];
   logic [VALUE_W-1:0] rd_a_ff;
   logic [VALUE_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         entries_ff[cmd.wr_addr] <= cmd.wr_data;
      end
      rd_a_ff <= entries_ff[cmd.rd_addr_a];
      rd_b_ff <= entries_ff[cmd.rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

/* hdl/blst_ctrl.sv */
module blst_ctrl
   import blst_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [CAP_W-1:0]   cap,
   input  logic               req_valid,
   output logic               req_ready,
   input  blst_req_type       req_data,
   input  logic               out_free,
   output logic               res_valid,
   output blst_rsp_type       res_data,
   output blst_ram_cmd_type   ram_cmd,
   input  logic [VALUE_W-1:0] rd_data_a,
   input  logic [VALUE_W-1:0] rd_data_b
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_SCAN, ST_SHIFT, ST_REV_RD, ST_REV_W1, ST_REV_W2,
      ST_DD_RD, ST_DD_KEY, ST_DONE
   } state_type;

   state_type                state_ff, state_in;
   logic [FUNC_W-1:0]        op_ff, op_in;
   logic [VALUE_W-1:0]       key_ff, key_in;
   logic [VALUE_W-1:0]       tmp_ff, tmp_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         scan_ff, scan_in;
   logic                     pend_ff, pend_in;
   logic [CNT_W-1:0]         pend_addr_ff, pend_addr_in;
   logic [CNT_W-1:0]         i_ff, i_in;
   logic [CNT_W-1:0]         j_ff, j_in;
   logic [CNT_W-1:0]         w_ff, w_in;
   logic signed [IDX_W-1:0]  res_idx_ff, res_idx_in;
   logic [STATUS_W-1:0]      res_status_ff, res_status_in;

   logic             match;
   logic             hit;
   logic             more;
   logic             room;
   logic [CNT_W-1:0] limit;
   logic [CNT_W-1:0] pend_prev;

   // shared compare unit: port B data against the key
   assign match     = (rd_data_b == key_ff);
   assign hit       = pend_ff && match;
   assign limit     = (op_ff == FUNC_DEDUP) ? w_ff : count_ff;
   assign more      = (scan_ff < limit);
   assign pend_prev = pend_addr_ff - 1'b1;
   assign room      = (CMP_W'(count_ff) < CMP_W'(cap)) && (CMP_W'(count_ff) < CMP_W'(DEPTH));

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      tmp_in        = tmp_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      pend_in       = pend_ff;
      pend_addr_in  = pend_addr_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      w_in          = w_ff;
      res_idx_in    = res_idx_ff;
      res_status_in = res_status_ff;
      req_ready     = 1'b0;
      res_valid     = 1'b0;
      ram_cmd.wr_en     = 1'b0;
      ram_cmd.wr_addr   = w_ff[ADDR_W-1:0];
      ram_cmd.wr_data   = key_ff;
      ram_cmd.rd_addr_a = scan_ff[ADDR_W-1:0];
      ram_cmd.rd_addr_b = scan_ff[ADDR_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in         = req_data.func;
               key_in        = req_data.value;
               res_idx_in    = IDX_NONE;
               res_status_in = STATUS_OK;
               scan_in       = '0;
               pend_in       = 1'b0;
               i_in          = '0;
               w_in          = '0;
               j_in          = count_ff - 1'b1;
               case (req_data.func)
                  FUNC_APPEND: begin
                     if (room) begin
                        ram_cmd.wr_en   = 1'b1;
                        ram_cmd.wr_addr = count_ff[ADDR_W-1:0];
                        ram_cmd.wr_data = req_data.value;
                        count_in        = count_ff + 1'b1;
                     end else begin
                        res_status_in = STATUS_FULL;
                     end
                     state_in = ST_DONE;
                  end
                  FUNC_FIND, FUNC_REMOVE: state_in = ST_SCAN;
                  FUNC_REVERSE: state_in = (count_ff > CNT_W'(1)) ? ST_REV_RD : ST_DONE;
                  FUNC_DEDUP: state_in = ST_DD_RD;
                  default: state_in = ST_DONE;
               endcase
            end
         end

         ST_SCAN: begin
            priority if (hit) begin
               case (op_ff)
                  FUNC_FIND: begin
                     res_idx_in = IDX_W'(pend_addr_ff);
                     state_in   = ST_DONE;
                  end
                  FUNC_REMOVE: begin
                     res_idx_in = IDX_W'(pend_addr_ff);
                     scan_in    = pend_addr_ff + 1'b1;
                     pend_in    = 1'b0;
                     state_in   = ST_SHIFT;
                  end
                  default: begin
                     // already kept: drop this one
                     pend_in  = 1'b0;
                     i_in     = i_ff + 1'b1;
                     state_in = ST_DD_RD;
                  end
               endcase
            end else if (more) begin
               pend_in      = 1'b1;
               pend_addr_in = scan_ff;
               scan_in      = scan_ff + 1'b1;
            end else begin
               pend_in = 1'b0;
               case (op_ff)
                  FUNC_FIND, FUNC_REMOVE: begin
                     res_status_in = STATUS_NOTFOUND;
                     state_in      = ST_DONE;
                  end
                  default: begin
                     // first occurrence: keep at the write slot
                     ram_cmd.wr_en = 1'b1;
                     w_in          = w_ff + 1'b1;
                     i_in          = i_ff + 1'b1;
                     state_in      = ST_DD_RD;
                  end
               endcase
            end
         end

         ST_SHIFT: begin
            if (pend_ff) begin
               ram_cmd.wr_en   = 1'b1;
               ram_cmd.wr_addr = pend_prev[ADDR_W-1:0];
               ram_cmd.wr_data = rd_data_a;
            end
            pend_in      = (scan_ff < count_ff);
            pend_addr_in = scan_ff;
            if (scan_ff < count_ff) begin
               scan_in = scan_ff + 1'b1;
            end else if (!pend_ff) begin
               count_in = count_ff - 1'b1;
               state_in = ST_DONE;
            end
         end

         ST_REV_RD: begin
            ram_cmd.rd_addr_a = i_ff[ADDR_W-1:0];
            ram_cmd.rd_addr_b = j_ff[ADDR_W-1:0];
            state_in = (i_ff < j_ff) ? ST_REV_W1 : ST_DONE;
         end

         ST_REV_W1: begin
            ram_cmd.wr_en   = 1'b1;
            ram_cmd.wr_addr = i_ff[ADDR_W-1:0];
            ram_cmd.wr_data = rd_data_b;
            tmp_in          = rd_data_a;
            state_in        = ST_REV_W2;
         end

         ST_REV_W2: begin
            ram_cmd.wr_en   = 1'b1;
            ram_cmd.wr_addr = j_ff[ADDR_W-1:0];
            ram_cmd.wr_data = tmp_ff;
            i_in            = i_ff + 1'b1;
            j_in            = j_ff - 1'b1;
            state_in        = ST_REV_RD;
         end

         ST_DD_RD: begin
            ram_cmd.rd_addr_a = i_ff[ADDR_W-1:0];
            if (i_ff < count_ff) begin
               state_in = ST_DD_KEY;
            end else begin
               count_in = w_ff;
               state_in = ST_DONE;
            end
         end

         ST_DD_KEY: begin
            key_in   = rd_data_a;
            scan_in  = '0;
            pend_in  = 1'b0;
            state_in = ST_SCAN;
         end

         ST_DONE: begin
            if (out_free) begin
               res_valid = 1'b1;
               state_in  = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      tmp_ff        <= tmp_in;
      scan_ff       <= scan_in;
      pend_addr_ff  <= pend_addr_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      w_ff          <= w_in;
      res_idx_ff    <= res_idx_in;
      res_status_ff <= res_status_in;
   end

   assign res_data.index  = res_idx_ff;
   assign res_data.count  = COUNT_W'(count_ff);
   assign res_data.status = res_status_ff;

endmodule

/* hdl/bounded_list_engine_top.sv */
// Append and unknown codes go straight to the done state; find scans to the match; remove
// scans to the match, then one shift step per cycle; reverse reads a pair, then writes
// each side in turn; dedup scans the kept prefix for each entry. The sequencer holds one
// beat at a time, with a single compare unit and a one-write-port list RAM. Synchronous
// active-high reset clears the count and sets the capacity to 64; list storage is not
// cleared and needs no sweep.
module bounded_list_engine_top
   import blst_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  blst_req_type     req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output blst_rsp_type     rsp_data,
   input  logic             csr_wr_en,
   input  logic [CAP_W-1:0] csr_wr_data
);

   logic [CAP_W-1:0]   cap_ff;
   logic               rsp_valid_ff;
   blst_rsp_type       rsp_data_ff;

   logic               out_free;
   logic               res_valid;
   blst_rsp_type       res_data;
   blst_ram_cmd_type   ram_cmd;
   logic [VALUE_W-1:0] rd_data_a;
   logic [VALUE_W-1:0] rd_data_b;

   // capacity register: to be written only while idle; the block itself does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_wr_en) begin
         cap_ff <= csr_wr_data;
      end
   end

   // the sequencer may finish a beat whenever the response slot is empty
   // or is being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   blst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cap       (cap_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .out_free  (out_free),
      .res_valid (res_valid),
      .res_data  (res_data),
      .ram_cmd   (ram_cmd),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // list storage: one write port, two registered read ports
   blst_ram u_ram (
      .clock     (clock),
      .cmd       (ram_cmd),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // response register: load a finished beat, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (res_valid) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* tb/sv/bounded_list_engine_top_tb.sv */
`timescale 1ns / 1ps

module bounded_list_engine_top_tb;
   import blst_pkg::*;

   // Dedup of a full list is the slowest beat; allow
   // that several times over, plus the longest stall on either side.
   localparam int QUIET_LIMIT  = 40000;
   localparam int PHASE_ITEMS  = 100;
   localparam int RAND_PHASES  = 16;
   localparam int SETTLE_TICKS = 50;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   blst_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   blst_rsp_type rsp_data;
   logic         csr_wr_en = 1'b0;
   logic [CAP_W-1:0] csr_wr_data = '0;

   bounded_list_engine_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #2 clock = ~clock;

   // Shadow of the list held by the block, plus its capacity register.
   logic [VALUE_W-1:0] list_mem [DEPTH];
   int                 list_len = 0;
   logic [CAP_W-1:0]   cap_shadow = CAP_RESET;

   blst_req_type pending_reqs [$];
   blst_rsp_type predicted_rsps [$];

   logic [VALUE_W-1:0] hot_vals [8];
   bit   send_idle_on = 1'b1;
   bit   recv_idle_on = 1'b1;
   int   mismatch_count = 0;
   int   quiet_cycles = 0;
   int   req_gap = 0;
   int   rsp_wait = 0;
   bit   req_took = 1'b0;
   bit   rsp_took = 1'b0;

   // First position holding the value among the live entries, or -1.
   function automatic int list_find(logic [VALUE_W-1:0] v);
      for (int i = 0; i < list_len; i++) begin
         if (list_mem[i] == v) return i;
      end
      return -1;
   endfunction

   // Apply one operation to the shadow list and return the response it yields.
   function automatic blst_rsp_type apply_list_op(blst_req_type rq);
      blst_rsp_type r;
      int lim, pos, i, j, w;
      bit seen;
      logic [VALUE_W-1:0] t;
      r.index  = IDX_NONE;
      r.status = STATUS_OK;
      lim = (int'(cap_shadow) > DEPTH) ? DEPTH : int'(cap_shadow);
      case (rq.func)
         FUNC_APPEND: begin
            if (list_len < lim) begin
               list_mem[list_len] = rq.value;
               list_len++;
            end else begin
               r.status = STATUS_FULL;
            end
         end
         FUNC_FIND: begin
            pos = list_find(rq.value);
            if (pos >= 0) r.index = IDX_W'(pos);
            else r.status = STATUS_NOTFOUND;
         end
         FUNC_REMOVE: begin
            pos = list_find(rq.value);
            if (pos >= 0) begin
               r.index = IDX_W'(pos);
               for (i = pos; i + 1 < list_len; i++) list_mem[i] = list_mem[i + 1];
               list_len--;
            end else begin
               r.status = STATUS_NOTFOUND;
            end
         end
         FUNC_REVERSE: begin
            i = 0;
            j = list_len - 1;
            while (i < j) begin
               t = list_mem[i];
               list_mem[i] = list_mem[j];
               list_mem[j] = t;
               i++;
               j--;
            end
         end
         FUNC_DEDUP: begin
            // Keep the first copy of each value; later copies, adjacent or not, go.
            w = 0;
            for (i = 0; i < list_len; i++) begin
               seen = 1'b0;
               for (j = 0; j < w; j++) begin
                  if (list_mem[j] == list_mem[i]) seen = 1'b1;
               end
               if (!seen) begin
                  list_mem[w] = list_mem[i];
                  w++;
               end
            end
            list_len = w;
         end
         default: ;
      endcase
      r.count = COUNT_W'(list_len);
      return r;
   endfunction

   // Wait time for one beat: zero while idling is off, else mostly short.
   function automatic int draw_wait(bit idle_on);
      if (!idle_on) return 0;
      if ($urandom_range(0, 9) < 5) return 0;
      return $urandom_range(1, 16);
   endfunction

   // Build one random request; mix 0 grows the list, 1 balances, 2 shrinks it.
   function automatic blst_req_type make_item(int mix);
      blst_req_type rq;
      int r, k;
      r = $urandom_range(0, 99);
      case (mix)
         0:       k = (r < 70) ? 0 : (r < 80) ? 1 : (r < 88) ? 2 : (r < 93) ? 3 : (r < 97) ? 4 : 5;
         1:       k = (r < 40) ? 0 : (r < 60) ? 1 : (r < 80) ? 2 : (r < 88) ? 3 : (r < 95) ? 4 : 5;
         default: k = (r < 20) ? 0 : (r < 35) ? 1 : (r < 80) ? 2 : (r < 88) ? 3 : (r < 95) ? 4 : 5;
      endcase
      case (k)
         0:       rq.func = FUNC_APPEND;
         1:       rq.func = FUNC_FIND;
         2:       rq.func = FUNC_REMOVE;
         3:       rq.func = FUNC_REVERSE;
         4:       rq.func = FUNC_DEDUP;
         default: rq.func = FUNC_W'($urandom_range(5, 7));
      endcase
      // Draw mostly from a small pool so finds hit and duplicates pile up.
      r = $urandom_range(0, 9);
      if (r < 6) begin
         rq.value = hot_vals[$urandom_range(0, 7)];
      end else if (r == 6) begin
         case ($urandom_range(0, 3))
            0:       rq.value = 32'h8000_0000;
            1:       rq.value = 32'h7FFF_FFFF;
            2:       rq.value = 32'h0000_0000;
            default: rq.value = 32'hFFFF_FFFF;
         endcase
      end else begin
         rq.value = $urandom();
      end
      return rq;
   endfunction

   task automatic queue_req(logic [FUNC_W-1:0] f, logic [VALUE_W-1:0] v);
      blst_req_type rq;
      rq.func  = f;
      rq.value = v;
      pending_reqs.push_back(rq);
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   // Hold the sender until every queued beat is out and every response is back.
   // Sample at the rising edge, where the queue and req_valid are settled.
   task automatic drain_list();
      do @(posedge clock);
      while (pending_reqs.size() != 0 || req_valid || predicted_rsps.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   // Write the capacity register; the block is idle here, so the shadow
   // can follow at once.
   task automatic write_capacity(logic [CAP_W-1:0] v);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      cap_shadow   = v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Sender: advance to the next beat only once the current one is taken,
   // then hold off for the gap drawn with it.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (req_gap > 0) begin
            req_gap   <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            req_data  <= pending_reqs.pop_front();
            req_valid <= 1'b1;
            req_gap   <= draw_wait(send_idle_on);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: after each taken response, drop ready for a drawn stall.
   always @(negedge clock) begin : recv_side
      int n;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_took) begin
         n = draw_wait(recv_idle_on);
         rsp_wait  <= n;
         rsp_ready <= (n == 0);
      end else if (rsp_wait > 0) begin
         rsp_wait  <= rsp_wait - 1;
         rsp_ready <= (rsp_wait == 1);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Monitor: predict on every accepted request beat, check every response
   // beat against the oldest prediction, and watch for a stalled block.
   always @(posedge clock) begin : monitor
      blst_rsp_type want;
      if (reset) begin
         req_took     <= 1'b0;
         rsp_took     <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         req_took <= req_valid && req_ready;
         rsp_took <= rsp_valid && rsp_ready;
         if (req_valid && req_ready) predicted_rsps.push_back(apply_list_op(req_data));
         if (rsp_valid && rsp_ready) begin
            if (predicted_rsps.size() == 0) begin
               report_mismatch("unexpected response, count", rsp_data.count, -1);
            end else begin
               want = predicted_rsps.pop_front();
               if (rsp_data.index !== want.index)
                  report_mismatch("index", rsp_data.index, want.index);
               if (rsp_data.count !== want.count)
                  report_mismatch("count", rsp_data.count, want.count);
               if (rsp_data.status !== want.status)
                  report_mismatch("status", rsp_data.status, want.status);
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin : stimulus
      logic [CAP_W-1:0] caps [8] = '{7'd8, 7'd0, 7'd1, 7'd127, 7'd2, 7'd64, 7'd65, 7'd3};
      logic [CAP_W-1:0] cap_next;
      for (int i = 0; i < 8; i++) hot_vals[i] = $urandom();

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: every operation on an empty list, unknown codes, the value
      // extremes, a middle removal, reverse, and dedup of adjacent and non-adjacent repeats.
      queue_req(FUNC_FIND, 32'h0);
      queue_req(FUNC_REMOVE, 32'h0);
      queue_req(FUNC_REVERSE, 32'h0);
      queue_req(FUNC_DEDUP, 32'h0);
      queue_req(FUNC_W'(5), 32'h0);
      queue_req(FUNC_W'(6), 32'hFFFF_FFFF);
      queue_req(FUNC_W'(7), 32'h7FFF_FFFF);
      queue_req(FUNC_APPEND, 32'h8000_0000);
      queue_req(FUNC_APPEND, 32'h7FFF_FFFF);
      queue_req(FUNC_APPEND, 32'h0);
      queue_req(FUNC_APPEND, 32'hFFFF_FFFF);
      queue_req(FUNC_APPEND, 32'd5);
      queue_req(FUNC_APPEND, 32'd5);
      queue_req(FUNC_APPEND, 32'h8000_0000);
      queue_req(FUNC_FIND, 32'h7FFF_FFFF);
      queue_req(FUNC_FIND, 32'd12345);
      queue_req(FUNC_REMOVE, 32'h0);
      queue_req(FUNC_REVERSE, 32'h0);
      queue_req(FUNC_DEDUP, 32'h0);
      queue_req(FUNC_FIND, 32'd5);
      queue_req(FUNC_REMOVE, 32'h8000_0000);
      queue_req(FUNC_FIND, 32'hFFFF_FFFF);
      drain_list();

      // Random phases: the first runs at the reset capacity, the rest cycle
      // through the extremes, a limit below the count, then random limits.
      for (int p = 0; p < RAND_PHASES; p++) begin
         if (p > 0) begin
            cap_next = (p <= 8) ? caps[p - 1] : CAP_W'($urandom_range(0, 127));
            write_capacity(cap_next);
         end
         send_idle_on = (p % 4 != 2);
         recv_idle_on = (p % 4 != 3);
         for (int k = 0; k < PHASE_ITEMS; k++) pending_reqs.push_back(make_item(p % 3));
         drain_list();
      end

      repeat (SETTLE_TICKS) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* sim.f */
hdl/blst_pkg.sv
hdl/blst_ram.sv
hdl/blst_ctrl.sv
hdl/bounded_list_engine_top.sv
tb/sv/bounded_list_engine_top_tb.sv
